### hdl/lpvs_pkg.sv
// Shared types and constants for the label propagation vertex step.
`default_nettype none

package lpvs_pkg;

   localparam int LABEL_W = 64;
   localparam int ROUNDS_W = 8;
   localparam int MAX_MESSAGES_DEFAULT = 64;

   localparam logic [ROUNDS_W-1:0] STABILITY_LIMIT_RESET = 8'd20;
   localparam logic [ROUNDS_W-1:0] ROUNDS_CEILING = 8'd255;

   typedef enum logic [1:0] {
      CMD_SET_VERTEX    = 2'd0,
      CMD_MESSAGE       = 2'd1,
      CMD_SUPERSTEP_END = 2'd2
   } command_type;

   typedef enum logic {
      S_IDLE,
      S_VOTE
   } top_state_type;

   typedef enum logic [2:0] {
      V_IDLE,
      V_FETCH,
      V_LOAD,
      V_SCAN,
      V_TALLY,
      V_DONE
   } vote_state_type;

   typedef struct packed {
      logic               done;
      logic [LABEL_W-1:0] label;
   } vote_status_type;

endpackage

`default_nettype wire

### hdl/label_propagation_vertex_step.sv
// Top level of the label propagation vertex step.
//
//   Channel  Direction  Handshake              Beat
//   req      in         req_valid/req_ready    command, label value, first superstep
//   rsp      out        rsp_valid/rsp_ready    broadcast, label, overflow, stable count
//   csr      in         csr_wr_en              stability limit
//
// Set-vertex, message, ignored, first-superstep and empty superstep-end beats load the result register directly.
// A superstep-end beat with buffered messages waits for the vote unit, which scans
// the buffer through the single RAM read port for each message.
// The message buffer needs no clearing at reset.
// A new beat is taken while no vote is running and the result register is empty or being drained.
`default_nettype none

module label_propagation_vertex_step
   import lpvs_pkg::*;
#(
   parameter int MAX_MESSAGES = MAX_MESSAGES_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [1:0]           req_command,
   input  wire logic [LABEL_W-1:0]   req_label_value,
   input  wire logic                 req_first_superstep,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_broadcast,
   output logic      [LABEL_W-1:0]   rsp_current_label,
   output logic                      rsp_overflow,
   output logic      [ROUNDS_W-1:0]  rsp_stable_count,
   input  wire logic                 csr_wr_en,
   input  wire logic [ROUNDS_W-1:0]  csr_wr_data
);

   localparam int CNT_W = $clog2(MAX_MESSAGES + 1);
   localparam int ADDR_W = $clog2(MAX_MESSAGES);

   top_state_type       state_ff, state_in;
   logic [LABEL_W-1:0]  vertex_label_ff, vertex_label_in;
   logic [LABEL_W-1:0]  previous_label_ff, previous_label_in;
   logic [ROUNDS_W-1:0] stable_rounds_ff, stable_rounds_in;
   logic [CNT_W-1:0]    message_count_ff, message_count_in;
   logic [ROUNDS_W-1:0] stability_limit_ff, stability_limit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_broadcast_ff, rsp_broadcast_in;
   logic [LABEL_W-1:0]  rsp_current_label_ff, rsp_current_label_in;
   logic                rsp_overflow_ff, rsp_overflow_in;
   logic [ROUNDS_W-1:0] rsp_stable_count_ff, rsp_stable_count_in;

   logic                take;
   logic                load;
   logic                apply;
   logic                broadcast;
   logic                overflow;
   logic                change;
   logic                vote_start;
   logic                ram_wr_en;
   logic [LABEL_W-1:0]  next_label;
   logic [ROUNDS_W-1:0] stable_step;
   logic [ADDR_W-1:0]   ram_rd_addr;
   logic [LABEL_W-1:0]  ram_rd_data;
   vote_status_type     vote_status;

   lpvs_ram #(
      .WIDTH(LABEL_W),
      .DEPTH(MAX_MESSAGES)
   ) u_buffer (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(message_count_ff[ADDR_W-1:0]),
      .wr_data(req_label_value),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   lpvs_vote #(
      .MAX_MESSAGES(MAX_MESSAGES)
   ) u_vote (
      .clock       (clock),
      .reset       (reset),
      .start       (vote_start),
      .msg_count   (message_count_ff),
      .vertex_label(vertex_label_ff),
      .rd_addr     (ram_rd_addr),
      .rd_data     (ram_rd_data),
      .status      (vote_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= S_IDLE;
         vertex_label_ff    <= '0;
         previous_label_ff  <= '0;
         stable_rounds_ff   <= '0;
         message_count_ff   <= '0;
         stability_limit_ff <= STABILITY_LIMIT_RESET;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         vertex_label_ff    <= vertex_label_in;
         previous_label_ff  <= previous_label_in;
         stable_rounds_ff   <= stable_rounds_in;
         message_count_ff   <= message_count_in;
         stability_limit_ff <= stability_limit_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
      rsp_broadcast_ff     <= rsp_broadcast_in;
      rsp_current_label_ff <= rsp_current_label_in;
      rsp_overflow_ff      <= rsp_overflow_in;
      rsp_stable_count_ff  <= rsp_stable_count_in;
   end

   always_comb begin
      state_in             = state_ff;
      vertex_label_in      = vertex_label_ff;
      previous_label_in    = previous_label_ff;
      stable_rounds_in     = stable_rounds_ff;
      message_count_in     = message_count_ff;
      stability_limit_in   = csr_wr_en ? csr_wr_data : stability_limit_ff;
      rsp_valid_in         = rsp_valid_ff;
      rsp_broadcast_in     = rsp_broadcast_ff;
      rsp_current_label_in = rsp_current_label_ff;
      rsp_overflow_in      = rsp_overflow_ff;
      rsp_stable_count_in  = rsp_stable_count_ff;

      req_ready  = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
      take       = req_valid && req_ready;
      load       = 1'b0;
      apply      = 1'b0;
      broadcast  = 1'b0;
      overflow   = 1'b0;
      vote_start = 1'b0;
      ram_wr_en  = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      next_label  = (state_ff == S_VOTE) ? vote_status.label : vertex_label_ff;
      stable_step = stable_rounds_ff;
      if ((previous_label_ff == next_label) && (stable_rounds_ff < ROUNDS_CEILING)) begin
         stable_step = stable_rounds_ff + ROUNDS_W'(1);
      end
      change = (next_label != vertex_label_ff) && (stable_step <= stability_limit_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               unique case (req_command)
                  CMD_SET_VERTEX: begin
                     vertex_label_in   = req_label_value;
                     previous_label_in = '0;
                     stable_rounds_in  = '0;
                     message_count_in  = '0;
                     load              = 1'b1;
                  end
                  CMD_MESSAGE: begin
                     if (message_count_ff < CNT_W'(MAX_MESSAGES)) begin
                        ram_wr_en        = 1'b1;
                        message_count_in = message_count_ff + CNT_W'(1);
                     end else begin
                        overflow = 1'b1;
                     end
                     load = 1'b1;
                  end
                  CMD_SUPERSTEP_END: begin
                     if (req_first_superstep) begin
                        broadcast        = 1'b1;
                        message_count_in = '0;
                        load             = 1'b1;
                     end else if (message_count_ff == '0) begin
                        apply = 1'b1;
                        load  = 1'b1;
                     end else begin
                        vote_start = 1'b1;
                        state_in   = S_VOTE;
                     end
                  end
                  default: begin
                     load = 1'b1;
                  end
               endcase
            end
         end
         S_VOTE: begin
            if (vote_status.done) begin
               apply            = 1'b1;
               message_count_in = '0;
               load             = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (apply) begin
         stable_rounds_in = stable_step;
         if (change) begin
            previous_label_in = vertex_label_ff;
            vertex_label_in   = next_label;
            stable_rounds_in  = '0;
            broadcast         = 1'b1;
         end
      end

      if (load) begin
         rsp_valid_in         = 1'b1;
         rsp_broadcast_in     = broadcast;
         rsp_current_label_in = vertex_label_in;
         rsp_overflow_in      = overflow;
         rsp_stable_count_in  = stable_rounds_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_broadcast     = rsp_broadcast_ff;
   assign rsp_current_label = rsp_current_label_ff;
   assign rsp_overflow      = rsp_overflow_ff;
   assign rsp_stable_count  = rsp_stable_count_ff;

endmodule

`default_nettype wire

### hdl/lpvs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lpvs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hdl/lpvs_vote.sv
// Vote unit: modal label, lower on ties; if no repeats, min with vertex.
`default_nettype none

module lpvs_vote
   import lpvs_pkg::*;
#(
   parameter int MAX_MESSAGES = MAX_MESSAGES_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [$clog2(MAX_MESSAGES+1)-1:0]   msg_count,
   input  wire logic [LABEL_W-1:0]                  vertex_label,
   output logic      [$clog2(MAX_MESSAGES)-1:0]     rd_addr,
   input  wire logic [LABEL_W-1:0]                  rd_data,
   output vote_status_type                          status
);

   localparam int CNT_W = $clog2(MAX_MESSAGES + 1);
   localparam int ADDR_W = $clog2(MAX_MESSAGES);

   vote_state_type     state_ff, state_in;
   logic [CNT_W-1:0]   i_ff, i_in;
   logic [CNT_W-1:0]   j_ff, j_in;
   logic [CNT_W-1:0]   hits_ff, hits_in;
   logic [CNT_W-1:0]   best_hits_ff, best_hits_in;
   logic [LABEL_W-1:0] best_ff, best_in;
   logic [LABEL_W-1:0] smallest_ff, smallest_in;
   logic [LABEL_W-1:0] v_ff, v_in;
   logic [LABEL_W-1:0] low_label;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= V_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff         <= i_in;
      j_ff         <= j_in;
      hits_ff      <= hits_in;
      best_hits_ff <= best_hits_in;
      best_ff      <= best_in;
      smallest_ff  <= smallest_in;
      v_ff         <= v_in;
   end

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      hits_in      = hits_ff;
      best_hits_in = best_hits_ff;
      best_in      = best_ff;
      smallest_in  = smallest_ff;
      v_in         = v_ff;
      rd_addr      = i_ff[ADDR_W-1:0];
      low_label    = (smallest_ff < vertex_label) ? smallest_ff : vertex_label;
      status.done  = 1'b0;
      status.label = (best_hits_ff <= CNT_W'(1)) ? low_label : best_ff;

      unique case (state_ff)
         V_IDLE: begin
            if (start) begin
               i_in         = '0;
               best_hits_in = '0;
               state_in     = V_FETCH;
            end
         end
         V_FETCH: begin
            rd_addr  = i_ff[ADDR_W-1:0];
            state_in = V_LOAD;
         end
         V_LOAD: begin
            v_in = rd_data;
            if ((i_ff == '0) || (rd_data < smallest_ff)) begin
               smallest_in = rd_data;
            end
            rd_addr  = '0;
            j_in     = CNT_W'(1);
            hits_in  = '0;
            state_in = V_SCAN;
         end
         V_SCAN: begin
            if (rd_data == v_ff) begin
               hits_in = hits_ff + CNT_W'(1);
            end
            if (j_ff < msg_count) begin
               rd_addr = j_ff[ADDR_W-1:0];
               j_in    = j_ff + CNT_W'(1);
            end else begin
               state_in = V_TALLY;
            end
         end
         V_TALLY: begin
            if ((hits_ff > best_hits_ff) ||
                ((hits_ff == best_hits_ff) && (v_ff < best_ff))) begin
               best_hits_in = hits_ff;
               best_in      = v_ff;
            end
            i_in = i_ff + CNT_W'(1);
            if ((i_ff + CNT_W'(1)) == msg_count) begin
               state_in = V_DONE;
            end else begin
               state_in = V_FETCH;
            end
         end
         V_DONE: begin
            status.done = 1'b1;
            state_in    = V_IDLE;
         end
         default: begin
            state_in = V_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### hdl/lpvs_checker.sv
// Port-level assertions for the label propagation vertex step, bound to the top level.
`default_nettype none

module lpvs_checker
   import lpvs_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic [1:0]          req_command,
   input wire logic [LABEL_W-1:0]  req_label_value,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic                rsp_broadcast,
   input wire logic [LABEL_W-1:0]  rsp_current_label,
   input wire logic                rsp_overflow,
   input wire logic [ROUNDS_W-1:0] rsp_stable_count
);

   logic set_taken;

   assign set_taken = req_valid && req_ready && (req_command == CMD_SET_VERTEX);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_current_label))
      else $error("Stalled result beat changed.");

   a_no_take_when_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("Request taken while result register is blocked.");

   a_overflow_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_overflow && rsp_broadcast))
      else $error("Dropped message beat also broadcasts.");

   a_set_result: assert property (@(posedge clock) disable iff (reset)
      set_taken |=> rsp_valid && !rsp_broadcast && !rsp_overflow &&
                    (rsp_stable_count == '0) &&
                    (rsp_current_label == $past(req_label_value)))
      else $error("Set-vertex beat did not give its result in the next cycle.");

endmodule

bind label_propagation_vertex_step lpvs_checker u_checker (.*);

`default_nettype wire

### sim/label_propagation_vertex_step_test.sv
// Self-checking testbench for the label propagation vertex step with its own vertex predictor.
`default_nettype none

module label_propagation_vertex_step_test;
   import lpvs_pkg::*;

   localparam logic [1:0] CMD_IGNORED = 2'd3;
   localparam int INBOX_DEPTH = MAX_MESSAGES_DEFAULT;
   localparam int IDLE_PERCENT = 17;
   localparam int LIMIT_CYCLES = 400000;
   localparam int HOLDOFF_CYCLES = 80;
   localparam logic [LABEL_W-1:0] ALL_ONES = '1;

   typedef struct packed {
      logic [1:0]         command;
      logic [LABEL_W-1:0] label;
      logic               first;
   } vertex_beat_type;

   typedef struct packed {
      logic                broadcast;
      logic [LABEL_W-1:0]  label;
      logic                overflow;
      logic [ROUNDS_W-1:0] rounds;
   } vertex_report_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_command = CMD_SET_VERTEX;
   logic [LABEL_W-1:0]  req_label_value = '0;
   logic                req_first_superstep = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_broadcast;
   logic [LABEL_W-1:0]  rsp_current_label;
   logic                rsp_overflow;
   logic [ROUNDS_W-1:0] rsp_stable_count;
   logic                csr_wr_en = 1'b0;
   logic [ROUNDS_W-1:0] csr_wr_data = '0;

   vertex_beat_type   queued_beats[$];
   vertex_report_type pending_reports[$];
   int             beats_queued = 0;
   int             beats_taken = 0;
   int             reports_seen = 0;
   int             mismatches = 0;
   logic           req_fired = 1'b0;
   logic           steady = 1'b0;
   int             holdoff_left = 0;
   int             next_holdoff_at = 350;
   logic [LABEL_W-1:0] palette[3];

   logic [LABEL_W-1:0]  model_label;
   logic [LABEL_W-1:0]  model_previous;
   logic [ROUNDS_W-1:0] model_rounds;
   logic [ROUNDS_W-1:0] model_limit;
   logic [LABEL_W-1:0]  inbox[INBOX_DEPTH];
   int                  inbox_count;

   label_propagation_vertex_step #(
      .MAX_MESSAGES(INBOX_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_label_value(req_label_value),
      .req_first_superstep(req_first_superstep),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_broadcast(rsp_broadcast),
      .rsp_current_label(rsp_current_label),
      .rsp_overflow(rsp_overflow),
      .rsp_stable_count(rsp_stable_count),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [LABEL_W-1:0] voted_label();
      logic [LABEL_W-1:0] lowest;
      logic [LABEL_W-1:0] winner;
      int winner_hits;
      int hits;
      lowest = inbox[0];
      winner = inbox[0];
      winner_hits = 0;
      for (int i = 0; i < inbox_count; i++) begin
         hits = 0;
         if (inbox[i] < lowest) begin
            lowest = inbox[i];
         end
         for (int j = 0; j < inbox_count; j++) begin
            if (inbox[j] == inbox[i]) begin
               hits++;
            end
         end
         if (hits > winner_hits || (hits == winner_hits && inbox[i] < winner)) begin
            winner_hits = hits;
            winner = inbox[i];
         end
      end
      if (winner_hits <= 1) begin
         return (lowest < model_label) ? lowest : model_label;
      end
      return winner;
   endfunction

   function automatic vertex_report_type advance_vertex(vertex_beat_type beat);
      vertex_report_type outcome;
      logic [LABEL_W-1:0] next_label;
      outcome = '0;
      case (beat.command)
         CMD_SET_VERTEX: begin
            model_label = beat.label;
            model_previous = '0;
            model_rounds = '0;
            inbox_count = 0;
         end
         CMD_MESSAGE: begin
            if (inbox_count < INBOX_DEPTH) begin
               inbox[inbox_count] = beat.label;
               inbox_count++;
            end else begin
               outcome.overflow = 1'b1;
            end
         end
         CMD_SUPERSTEP_END: begin
            if (beat.first) begin
               outcome.broadcast = 1'b1;
            end else begin
               next_label = model_label;
               if (inbox_count > 0) begin
                  next_label = voted_label();
               end
               if (model_previous == next_label && model_rounds != ROUNDS_CEILING) begin
                  model_rounds++;
               end
               if (next_label != model_label && model_rounds <= model_limit) begin
                  model_previous = model_label;
                  model_label = next_label;
                  model_rounds = '0;
                  outcome.broadcast = 1'b1;
               end
            end
            inbox_count = 0;
         end
         default: begin
         end
      endcase
      outcome.label = model_label;
      outcome.rounds = model_rounds;
      return outcome;
   endfunction

   task automatic report_mismatch(input string what, input logic [LABEL_W-1:0] got,
                                  input logic [LABEL_W-1:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      vertex_beat_type   seen;
      vertex_report_type want;
      if (reset) begin
         model_label = '0;
         model_previous = '0;
         model_rounds = '0;
         model_limit = STABILITY_LIMIT_RESET;
         inbox_count = 0;
         req_fired = 1'b0;
      end else begin
         req_fired = req_valid && req_ready;
         if (csr_wr_en) begin
            model_limit = csr_wr_data;
         end
         if (req_fired) begin
            seen.command = req_command;
            seen.label = req_label_value;
            seen.first = req_first_superstep;
            pending_reports.push_back(advance_vertex(seen));
            beats_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            reports_seen++;
            if (pending_reports.size() == 0) begin
               report_mismatch("result beat with nothing expected", rsp_current_label, '0);
            end else begin
               want = pending_reports.pop_front();
               if (rsp_broadcast !== want.broadcast) begin
                  report_mismatch("broadcast", LABEL_W'(rsp_broadcast),
                                  LABEL_W'(want.broadcast));
               end
               if (rsp_current_label !== want.label) begin
                  report_mismatch("current_label", rsp_current_label, want.label);
               end
               if (rsp_overflow !== want.overflow) begin
                  report_mismatch("overflow", LABEL_W'(rsp_overflow),
                                  LABEL_W'(want.overflow));
               end
               if (rsp_stable_count !== want.rounds) begin
                  report_mismatch("stable_count", LABEL_W'(rsp_stable_count),
                                  LABEL_W'(want.rounds));
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      vertex_beat_type beat;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (queued_beats.size() != 0 && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
            beat = queued_beats.pop_front();
            req_command <= beat.command;
            req_label_value <= beat.label;
            req_first_superstep <= beat.first;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_ready <= 1'b0;
      end else if (reports_seen >= next_holdoff_at) begin
         holdoff_left = HOLDOFF_CYCLES;
         next_holdoff_at += 300;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || $urandom_range(99) >= IDLE_PERCENT;
      end
   end

   task automatic queue_beat(input logic [1:0] command, input logic [LABEL_W-1:0] label,
                             input logic first);
      vertex_beat_type beat;
      beat.command = command;
      beat.label = label;
      beat.first = first;
      queued_beats.push_back(beat);
      beats_queued++;
   endtask

   task automatic refresh_palette();
      palette[0] = LABEL_W'($urandom_range(15));
      palette[1] = {$urandom, $urandom};
      palette[2] = LABEL_W'($urandom_range(15));
   endtask

   function automatic logic [LABEL_W-1:0] palette_label();
      case ($urandom_range(9))
         0: return '0;
         1: return ALL_ONES;
         2: return {$urandom, $urandom};
         default: return palette[$urandom_range(2)];
      endcase
   endfunction

   task automatic queue_round();
      int pick;
      int burst;
      pick = $urandom_range(99);
      if (pick < 8) begin
         refresh_palette();
         queue_beat(CMD_SET_VERTEX, palette_label(), 1'($urandom_range(1)));
      end else if (pick < 12) begin
         queue_beat($urandom_range(1) ? CMD_IGNORED : 2'($urandom_range(3)),
                    {$urandom, $urandom}, 1'($urandom_range(1)));
      end else begin
         burst = ($urandom_range(99) < 6) ? $urandom_range(20) : $urandom_range(6);
         repeat (burst) begin
            queue_beat(CMD_MESSAGE, palette_label(), 1'($urandom_range(1)));
         end
         queue_beat(CMD_SUPERSTEP_END, {$urandom, $urandom}, $urandom_range(99) < 10);
      end
   endtask

   task automatic queue_rounds(input int count);
      int stop_at;
      stop_at = beats_queued + count;
      while (beats_queued < stop_at) begin
         queue_round();
      end
   endtask

   task automatic queue_flood();
      repeat (INBOX_DEPTH + $urandom_range(1, 4)) begin
         queue_beat(CMD_MESSAGE, palette_label(), 1'($urandom_range(1)));
      end
      queue_beat(CMD_SUPERSTEP_END, {$urandom, $urandom}, 1'b0);
   endtask

   task automatic wait_for_quiet();
      @(negedge clock);
      while (beats_taken != beats_queued || pending_reports.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_limit(input logic [ROUNDS_W-1:0] value);
      wait_for_quiet();
      repeat (4) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      refresh_palette();
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      queue_beat(CMD_SET_VERTEX, '0, 1'b1);
      queue_beat(CMD_SUPERSTEP_END, ALL_ONES, 1'b1);
      queue_beat(CMD_SUPERSTEP_END, '0, 1'b0);
      queue_beat(CMD_IGNORED, ALL_ONES, 1'b1);
      queue_beat(CMD_SET_VERTEX, ALL_ONES, 1'b0);
      queue_beat(CMD_MESSAGE, 64'd7, 1'b0);
      queue_beat(CMD_MESSAGE, 64'd3, 1'b0);
      queue_beat(CMD_SUPERSTEP_END, '0, 1'b0);
      queue_beat(CMD_MESSAGE, 64'd9, 1'b0);
      queue_beat(CMD_MESSAGE, 64'd9, 1'b0);
      queue_beat(CMD_MESSAGE, 64'd4, 1'b0);
      queue_beat(CMD_MESSAGE, 64'd4, 1'b0);
      queue_beat(CMD_MESSAGE, ALL_ONES, 1'b0);
      queue_beat(CMD_SUPERSTEP_END, '0, 1'b0);
      queue_beat(CMD_MESSAGE, '0, 1'b1);
      queue_beat(CMD_MESSAGE, '0, 1'b0);
      queue_beat(CMD_SUPERSTEP_END, '0, 1'b1);
      queue_beat(CMD_SUPERSTEP_END, '0, 1'b0);
      queue_beat(CMD_MESSAGE, 64'd5, 1'b0);
      queue_beat(CMD_MESSAGE, 64'd5, 1'b0);
      queue_beat(CMD_MESSAGE, 64'd5, 1'b0);
      queue_beat(CMD_SET_VERTEX, {1'b1, 63'd0}, 1'b0);
      queue_beat(CMD_SUPERSTEP_END, ALL_ONES, 1'b0);
      queue_beat(CMD_IGNORED, '0, 1'b0);

      write_limit('0);
      steady = 1'b1;
      queue_beat(CMD_SET_VERTEX, '0, 1'b0);
      repeat (258) begin
         queue_beat(CMD_SUPERSTEP_END, {$urandom, $urandom}, 1'b0);
      end
      wait_for_quiet();
      @(posedge clock);
      steady = 1'b0;
      queue_rounds(50);

      write_limit(ROUNDS_CEILING);
      queue_rounds(40);
      queue_flood();
      queue_rounds(40);

      write_limit(ROUNDS_W'($urandom_range(1, 254)));
      queue_rounds(30);
      queue_flood();
      queue_rounds(30);

      write_limit(8'd1);
      queue_rounds(30);
      queue_flood();
      queue_rounds(30);

      wait_for_quiet();
      repeat (20) @(negedge clock);
      if (pending_reports.size() != 0) begin
         report_mismatch("results never delivered", '0, LABEL_W'(pending_reports.size()));
      end
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #(LIMIT_CYCLES * 12);
      $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
